[sv/ufrb_pkg.sv]
package ufrb_pkg;

    // Depth of the receive and transmit queues.
    localparam int FIFO_DEPTH = 14;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Transaction kinds on the input channel.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Internal register codes after the address aliasing.
    localparam logic [3:0] REG_RBR = 4'd0;
    localparam logic [3:0] REG_IER = 4'd1;
    localparam logic [3:0] REG_IIR = 4'd2;
    localparam logic [3:0] REG_LCR = 4'd3;
    localparam logic [3:0] REG_MCR = 4'd4;
    localparam logic [3:0] REG_LSR = 4'd5;
    localparam logic [3:0] REG_MSR = 4'd6;
    localparam logic [3:0] REG_SCR = 4'd7;
    localparam logic [3:0] REG_FCR = 4'd8;
    localparam logic [3:0] REG_DLL = 4'd9;
    localparam logic [3:0] REG_DLM = 4'd10;
    localparam logic [3:0] REG_THR = 4'd11;

    // Interrupt identification codes.
    localparam logic [7:0] IIR_NONE   = 8'd1;
    localparam logic [7:0] IIR_THRE   = 8'd2;
    localparam logic [7:0] IIR_RX     = 8'd4;
    localparam logic [7:0] IIR_RXFIFO = 8'd12;

    // Register bit masks.
    localparam logic [7:0] LSR_RX      = 8'h01;
    localparam logic [7:0] LSR_TX      = 8'h20;
    localparam logic [7:0] LSR_TE      = 8'h40;
    localparam logic [7:0] LSR_RESET   = 8'h60;
    localparam logic [7:0] FCR_RD_MASK = 8'hC0;
    localparam int         DIV_LATCH   = 7;
    localparam int         FCR_ENABLE  = 0;

    // Pending flag bit positions.
    localparam int PF_RECV = 0;
    localparam int PF_THRE = 1;
    localparam int PF_SINT = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] addr;
        logic [7:0] wdata;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } rxq_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       head_data;
    } rxq_stat_t;

endpackage

[sv/ufrb_in_stage.sv]
module ufrb_in_stage
    import ufrb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage holds while a transaction sits here and the core cannot take it.
    assign in_stall   = valid_reg && !item_take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/ufrb_rx_fifo.sv]
module ufrb_rx_fifo
    import ufrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rxq_ctrl_t ctrl,
    output rxq_stat_t stat
);

    logic [7:0]       data_reg [0:FIFO_DEPTH-1];
    logic [7:0]       head_data_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] tail;

    // Head plus count stays below twice the depth, so one subtract wraps it.
    assign tail_sum = (PTR_W+1)'(head_reg) + (PTR_W+1)'(count_reg);
    assign tail     = (tail_sum >= (PTR_W+1)'(FIFO_DEPTH))
                    ? PTR_W'(tail_sum - (PTR_W+1)'(FIFO_DEPTH))
                    : PTR_W'(tail_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            head_next  = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // The head entry is prefetched into a register from the next head pointer. A push into an empty queue
    // lands on the head slot, so that byte is forwarded directly.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg[tail] <= ctrl.push_data;
        end
        if (ctrl.push && tail == head_next)
        begin
            head_data_reg <= ctrl.push_data;
        end
        else
        begin
            head_data_reg <= data_reg[head_next];
        end
    end

    assign stat.count     = count_reg;
    assign stat.head_data = head_data_reg;

endmodule

[sv/ufrb_core.sv]
module ufrb_core
    import ufrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  item_t     item,
    output logic      item_take,
    output rxq_ctrl_t rxq_ctrl,
    input  rxq_stat_t rxq_stat,
    output logic      out_valid,
    input  logic      out_stall,
    output result_t   result
);

    logic [7:0]       rbr_reg, rbr_next;
    logic [7:0]       ier_reg, ier_next;
    logic [7:0]       iir_reg, iir_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [7:0]       mcr_reg, mcr_next;
    logic [7:0]       lsr_reg, lsr_next;
    logic [7:0]       msr_reg, msr_next;
    logic [7:0]       scr_reg, scr_next;
    logic [7:0]       fcr_reg, fcr_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic [2:0]       pf_reg, pf_next;
    logic             irq_reg, irq_next;
    logic [CNT_W-1:0] tx_count_reg, tx_count_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             go;
    logic             fifo_on;
    logic             dlab;
    logic [3:0]       ra;
    logic [7:0]       rd;
    logic             do_update;
    logic [CNT_W-1:0] rx_count_after;

    assign go        = item_valid && (!out_valid_reg || !out_stall);
    assign item_take = go;
    assign fifo_on   = fcr_reg[FCR_ENABLE];
    assign dlab      = lcr_reg[DIV_LATCH];

    always_comb
    begin
        rbr_next       = rbr_reg;
        ier_next       = ier_reg;
        iir_next       = iir_reg;
        lcr_next       = lcr_reg;
        mcr_next       = mcr_reg;
        lsr_next       = lsr_reg;
        msr_next       = msr_reg;
        scr_next       = scr_reg;
        fcr_next       = fcr_reg;
        dll_next       = dll_reg;
        dlm_next       = dlm_reg;
        pf_next        = pf_reg;
        irq_next       = irq_reg;
        tx_count_next  = tx_count_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        rxq_ctrl       = '0;
        rxq_ctrl.push_data = item.rx_byte;
        do_update      = 1'b0;
        rd             = '0;

        // Address aliasing: divisor latches under DLAB, FCR on writes to IIR, THR on writes to RBR.
        ra = {1'b0, item.addr};
        if (item.op == OP_WRITE && item.addr == REG_IIR[2:0])
        begin
            ra = REG_FCR;
        end
        else if (item.addr == REG_RBR[2:0] && dlab)
        begin
            ra = REG_DLL;
        end
        else if (item.addr == REG_IER[2:0] && dlab)
        begin
            ra = REG_DLM;
        end
        else if (item.addr == REG_RBR[2:0] && item.op == OP_WRITE)
        begin
            ra = REG_THR;
        end

        if (go)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;

            case (item.op)
                OP_READ:
                begin
                    unique case (ra)
                        REG_RBR: rd = rbr_reg;
                        REG_IER: rd = ier_reg;
                        REG_IIR: rd = iir_reg | (fcr_reg & FCR_RD_MASK);
                        REG_LCR: rd = lcr_reg;
                        REG_MCR: rd = mcr_reg;
                        REG_LSR: rd = lsr_reg;
                        REG_MSR: rd = msr_reg;
                        REG_SCR: rd = scr_reg;
                        REG_DLL: rd = dll_reg;
                        REG_DLM: rd = dlm_reg;
                        default: rd = '0;
                    endcase

                    if (ra == REG_RBR)
                    begin
                        if (fifo_on)
                        begin
                            if (rxq_stat.count != '0)
                            begin
                                rxq_ctrl.pop = 1'b1;
                                rbr_next     = rxq_stat.head_data;
                                if (rxq_stat.count == CNT_W'(1))
                                begin
                                    lsr_next = lsr_next & ~LSR_RX;
                                end
                                if (iir_next == IIR_RXFIFO)
                                begin
                                    irq_next          = 1'b0;
                                    iir_next          = IIR_NONE;
                                    pf_next[PF_RECV]  = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            lsr_next = lsr_next & ~LSR_RX;
                            if (iir_next == IIR_RX)
                            begin
                                irq_next         = 1'b0;
                                iir_next         = IIR_NONE;
                                pf_next[PF_RECV] = 1'b0;
                            end
                            do_update = 1'b1;
                        end
                        rd = rbr_next;
                    end
                    else if (ra == REG_LSR)
                    begin
                        lsr_next = lsr_next & ~LSR_RX;
                        if (iir_next == (fifo_on ? IIR_RXFIFO : IIR_RX))
                        begin
                            irq_next         = 1'b0;
                            iir_next         = IIR_NONE;
                            pf_next[PF_RECV] = 1'b0;
                        end
                    end
                    else if (ra == REG_IIR)
                    begin
                        iir_next = IIR_NONE;
                        irq_next = 1'b0;
                    end
                    res_next.rdata = rd;
                end

                OP_WRITE:
                begin
                    if (ra == REG_THR)
                    begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = item.wdata;
                        lsr_next          = lsr_next | LSR_TE;
                        if (fifo_on)
                        begin
                            if (tx_count_next != CNT_W'(FIFO_DEPTH))
                            begin
                                tx_count_next = tx_count_next + CNT_W'(1);
                            end
                            if (tx_count_next != CNT_W'(FIFO_DEPTH))
                            begin
                                lsr_next = lsr_next | LSR_RESET;
                            end
                            else
                            begin
                                lsr_next = lsr_next & ~LSR_RESET;
                            end
                        end
                        else if (iir_next == IIR_THRE)
                        begin
                            irq_next         = 1'b0;
                            iir_next         = IIR_NONE;
                            pf_next[PF_THRE] = 1'b0;
                        end
                        else
                        begin
                            pf_next[PF_THRE] = 1'b1;
                        end
                    end
                    else
                    begin
                        unique case (ra)
                            REG_IER: ier_next = item.wdata;
                            REG_LCR: lcr_next = item.wdata;
                            REG_MCR: mcr_next = item.wdata;
                            REG_LSR: lsr_next = item.wdata;
                            REG_MSR: msr_next = item.wdata;
                            REG_SCR: scr_next = item.wdata;
                            REG_FCR: fcr_next = item.wdata;
                            REG_DLL: dll_next = item.wdata;
                            REG_DLM: dlm_next = item.wdata;
                            default: ;
                        endcase
                    end
                end

                OP_TICK:
                begin
                    if (item.rx_valid)
                    begin
                        if (fifo_on ? (rxq_stat.count != CNT_W'(FIFO_DEPTH))
                                    : !pf_reg[PF_RECV])
                        begin
                            if (fifo_on)
                            begin
                                rxq_ctrl.push = 1'b1;
                            end
                            else
                            begin
                                rbr_next = item.rx_byte;
                            end
                            lsr_next          = lsr_next | LSR_RX;
                            pf_next[PF_RECV]  = 1'b1;
                            res_next.rx_taken = 1'b1;
                        end
                    end
                    do_update = 1'b1;
                end

                default: ;
            endcase

            // Interrupt update: in FIFO mode drain one transmit byte if any is queued, then pick the IIR code.
            rx_count_after = rxq_stat.count + CNT_W'(rxq_ctrl.push);
            if (do_update)
            begin
                if (fifo_on && tx_count_next != '0)
                begin
                    tx_count_next    = tx_count_next - CNT_W'(1);
                    lsr_next         = lsr_next | LSR_RESET;
                    pf_next[PF_THRE] = 1'b0;
                    pf_next[PF_SINT] = 1'b1;
                end

                if (fifo_on && rx_count_after != '0)
                begin
                    pf_next[PF_RECV] = 1'b0;
                    lsr_next         = lsr_next | LSR_RX;
                    iir_next         = IIR_RXFIFO;
                end
                else if (pf_next[PF_RECV] && !fifo_on)
                begin
                    pf_next[PF_RECV] = 1'b0;
                    iir_next         = IIR_RX;
                end
                else if ((pf_next[PF_THRE] || pf_next[PF_SINT]) && iir_next == IIR_NONE)
                begin
                    pf_next[PF_THRE] = 1'b0;
                    pf_next[PF_SINT] = 1'b0;
                    lsr_next         = lsr_next | LSR_RESET;
                    iir_next         = IIR_THRE;
                end
                else
                begin
                    lsr_next = lsr_next | LSR_RESET;
                    iir_next = IIR_NONE;
                end
                irq_next = (iir_next != IIR_NONE);
            end

            res_next.irq = irq_next;
        end
        else
        begin
            rx_count_after = rxq_stat.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbr_reg       <= '0;
            ier_reg       <= '0;
            iir_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            lsr_reg       <= LSR_RESET;
            msr_reg       <= '0;
            scr_reg       <= '0;
            fcr_reg       <= '0;
            dll_reg       <= '0;
            dlm_reg       <= '0;
            pf_reg        <= '0;
            irq_reg       <= 1'b0;
            tx_count_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rbr_reg       <= rbr_next;
            ier_reg       <= ier_next;
            iir_reg       <= iir_next;
            lcr_reg       <= lcr_next;
            mcr_reg       <= mcr_next;
            lsr_reg       <= lsr_next;
            msr_reg       <= msr_next;
            scr_reg       <= scr_next;
            fcr_reg       <= fcr_next;
            dll_reg       <= dll_next;
            dlm_reg       <= dlm_next;
            pf_reg        <= pf_next;
            irq_reg       <= irq_next;
            tx_count_reg  <= tx_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

[sv/uart_fifo_register_block_core.sv]
// A transaction accepted on the input channel is captured in the input register, then processed
// and written to the result register, from which it leaves on the result channel.
// Throughput: one transaction per cycle in both directions while the result channel does not stall;
// the single pass of register, flag and queue-pointer logic between the two registers sets this figure.
// Reset (rst_n low, asynchronous): register file and flags clear, line status reads 0x60, queues empty;
// queue storage and result payload are not cleared and only written entries are ever read.
module uart_fifo_register_block_core
    import ufrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // Input channel: bus reads, bus writes and line ticks.
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [2:0] addr,
    input  logic [7:0] wdata,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,

    // Result channel: one transaction for every input transaction.
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] rdata,
    output logic       irq,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       rx_taken
);

    item_t     in_item;
    item_t     item;
    logic      item_valid;
    logic      item_take;
    rxq_ctrl_t rxq_ctrl;
    rxq_stat_t rxq_stat;
    result_t   result;

    assign in_item.op       = op;
    assign in_item.addr     = addr;
    assign in_item.wdata    = wdata;
    assign in_item.rx_valid = rx_valid;
    assign in_item.rx_byte  = rx_byte;

    // The input register lets a new transaction enter while a result waits
    // in the output register; it stalls only when both are held.
    ufrb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // The receive queue is a circular buffer addressed by head and count.
    // Pushes come from ticks and pops from receive buffer reads, never both
    // in one cycle.
    ufrb_rx_fifo u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rxq_ctrl),
        .stat  (rxq_stat)
    );

    // The core holds the register file, the pending flags, the transmit
    // queue fill count and the result register. The transmit queue data is
    // never observable, so only its fill count is kept.
    ufrb_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .rxq_ctrl   (rxq_ctrl),
        .rxq_stat   (rxq_stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign rdata    = result.rdata;
    assign irq      = result.irq;
    assign tx_valid = result.tx_valid;
    assign tx_byte  = result.tx_byte;
    assign rx_taken = result.rx_taken;

endmodule

[sv/ufrb_checker.sv]
module ufrb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] rdata,
    input logic       irq,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       rx_taken
);

    // A held result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rdata) && $stable(irq)
            && $stable(tx_valid) && $stable(tx_byte) && $stable(rx_taken))
        else $error("result changed while stalled");

    // The input side only backs up when a result is waiting and stalled.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A transmitted byte comes from a write only.
    a_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> !rx_taken && rdata == 8'd0)
        else $error("transmit result carries read or receive data");

    // No byte shows on the line side without a transmit.
    a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("transmit byte without transmit");

endmodule

bind uart_fifo_register_block_core ufrb_checker u_ufrb_checker (.*);
